@@ rtl/core/cra_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_pkg
// Shared types, codes and sizes for the capability range allocator.
// ----------------------------------------------------------------------------
package cra_pkg;

    localparam int CAP_ENTRIES_DEF  = 256;
    localparam int DOMAIN_SLOTS_DEF = 64;
    localparam int SCAN_W           = 8;   // table entries checked per scan cycle

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DOMAIN = 3'd1;
    localparam logic [2:0] ST_NO_RANGE  = 3'd2;
    localparam logic [2:0] ST_LIMIT     = 3'd3;
    localparam logic [2:0] ST_BAD_LEVEL = 3'd4;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd5;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  cap_count;
        logic [5:0]  domain_slot;
        logic [31:0] entry_address;
        logic [5:0]  target_slot;
        logic [3:0]  iso_lvl;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot_out;
        logic [7:0] cap_index;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       pop;
        logic       push_req_slot;
        logic       push_alloc_slot;
        logic       scan_clear;
        logic       scan_step;
        logic       commit_alloc;
        logic       commit_add;
        logic       set_result;
        logic [2:0] res_status;
        logic       res_use_alloc;
        logic       res_use_add;
        logic       load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       list_empty;
        logic       slot_bad;
        logic       range_full;
        logic       level_bad;
        logic       scan_found;
        logic       scan_done;
    } sts_t;

endpackage

@@ rtl/core/capability_range_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capability_range_allocator_unit
// Domain slot free list plus first-fit capability range allocator.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request (allocate, free, add capability);
//   out_valid/out_ready return exactly one response per request, in order.
//   cfg_wr_en/cfg_wr_data write the max isolation level; write only when idle.
// Sequence: a request is captured, then decoded; a free, add, bad or unused
//   op then goes to the response state. An allocate pops a slot and scans
//   the table until a run fits or the table ends, marks the run when one was
//   found, then goes to the response state.
// Throughput: a new request can be taken in the cycle out_valid rises; the
//   unit finishes one request before it takes the next.
//   The first-fit scanner checks 8 table entries per cycle; that loop sets the
//   allocate time. One request is in flight at a time.
// Output register: a finished response is held in out_data while the next
//   request is accepted; a stalled receiver holds the unit in its response
//   state until the register drains, so in_ready drops meanwhile.
// Reset (rst_n, async): all slots free and linked in order, no table entry
//   taken, max level 15, no response pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module capability_range_allocator_unit
    import cra_pkg::*;
#(
    parameter int CAP_ENTRIES  = CAP_ENTRIES_DEF,
    parameter int DOMAIN_SLOTS = DOMAIN_SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  req_t       in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output rsp_t       out_data,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: owns handshakes and the response valid flag
    cra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // all tables, the scanner and the response payload
    cra_datapath #(
        .CAP_ENTRIES  (CAP_ENTRIES),
        .DOMAIN_SLOTS (DOMAIN_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_data    (out_data)
    );

endmodule

@@ rtl/core/cra_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_datapath
// Free list, taken map, domain and capability tables, first-fit scanner.
// ----------------------------------------------------------------------------
module cra_datapath
    import cra_pkg::*;
#(
    parameter int CAP_ENTRIES  = CAP_ENTRIES_DEF,
    parameter int DOMAIN_SLOTS = DOMAIN_SLOTS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  req_t       in_data,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    output rsp_t       out_data
);

    localparam int CW = (CAP_ENTRIES > 1) ? $clog2(CAP_ENTRIES) : 1;
    localparam int RW = $clog2(CAP_ENTRIES + 1);
    localparam int SW = (DOMAIN_SLOTS > 1) ? $clog2(DOMAIN_SLOTS) : 1;
    localparam int PW = $clog2(CAP_ENTRIES + SCAN_W) + 1;

    typedef struct packed {
        logic [CW-1:0] base;
        logic [RW-1:0] range;
        logic [RW-1:0] used;
    } dom_ent_t;

    typedef struct packed {
        logic [31:0]   addr;
        logic [SW-1:0] owner;
        logic [5:0]    target;
        logic [3:0]    level;
    } cap_ent_t;

    // storage
    logic [CAP_ENTRIES-1:0]  taken_reg;
    logic [DOMAIN_SLOTS-1:0] is_free_reg;
    logic [DOMAIN_SLOTS-1:0] nf_written_reg;
    logic [SW-1:0]           nf_mem [DOMAIN_SLOTS];
    dom_ent_t                dom_mem [DOMAIN_SLOTS];
    cap_ent_t                cap_mem [CAP_ENTRIES];

    logic [SW-1:0] free_head_reg;
    logic          list_empty_reg;
    logic [3:0]    max_level_reg;

    req_t          req_reg;
    logic [SW-1:0] nf_rd_reg;
    logic          nf_hit_reg;
    logic [SW-1:0] nf_head_reg;
    dom_ent_t      dom_rd_reg;
    logic          slot_bad_reg;

    logic [SW-1:0] alloc_slot_reg;
    logic [PW-1:0] pos_reg;
    logic [RW-1:0] run_reg;
    logic [CW-1:0] base_reg;

    rsp_t res_reg;
    rsp_t out_reg;

    logic [SW-1:0] req_slot;
    logic [SW-1:0] nf_val;
    logic [SW-1:0] nf_reset_val;
    logic [8:0]    need;
    logic [CW-1:0] add_idx;
    logic [SW-1:0] push_slot;
    logic          push_en;

    // scan chunk
    logic [PW-1:0] idx_v;
    logic [RW-1:0] run_v;
    logic          found_v;
    logic [CW-1:0] base_v;

    assign req_slot = SW'(req_reg.domain_slot);
    assign need     = {1'b0, req_reg.cap_count} + 9'd1;
    assign add_idx  = CW'({1'b0, dom_rd_reg.base} + (CW+1)'(dom_rd_reg.used));

    assign nf_reset_val = (32'(nf_head_reg) + 32'd1 < 32'(DOMAIN_SLOTS)) ?
                          SW'(nf_head_reg + 1'b1) : '0;
    assign nf_val       = nf_hit_reg ? nf_rd_reg : nf_reset_val;

    assign push_en   = cmd.push_req_slot | cmd.push_alloc_slot;
    assign push_slot = cmd.push_req_slot ? req_slot : alloc_slot_reg;

    always_comb
    begin
        run_v   = run_reg;
        found_v = 1'b0;
        base_v  = '0;
        idx_v   = '0;
        for (int k = 0; k < SCAN_W; k++)
        begin
            idx_v = pos_reg + PW'(k);
            if (!found_v)
            begin
                if (idx_v >= PW'(CAP_ENTRIES) || taken_reg[idx_v[CW-1:0]])
                begin
                    run_v = '0;
                end
                else
                begin
                    run_v = run_v + 1'b1;
                    if (32'(run_v) >= 32'(need))
                    begin
                        found_v = 1'b1;
                        base_v  = CW'(idx_v + PW'(1) - PW'(run_v));
                    end
                end
            end
        end
    end

    assign sts.op         = req_reg.op;
    assign sts.list_empty = list_empty_reg;
    assign sts.slot_bad   = slot_bad_reg;
    assign sts.range_full = dom_rd_reg.used >= dom_rd_reg.range;
    assign sts.level_bad  = req_reg.iso_lvl > max_level_reg;
    assign sts.scan_found = found_v;
    assign sts.scan_done  = (pos_reg + PW'(SCAN_W)) >= PW'(CAP_ENTRIES);

    // control-side state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg      <= '0;
            is_free_reg    <= '1;
            nf_written_reg <= '0;
            free_head_reg  <= '0;
            list_empty_reg <= 1'b0;
            max_level_reg  <= 4'd15;
        end
        else
        begin
            if (cfg_wr_en)
                max_level_reg <= cfg_wr_data;
            if (cmd.pop)
            begin
                is_free_reg[free_head_reg] <= 1'b0;
                free_head_reg              <= nf_val;
                list_empty_reg <= (nf_val == free_head_reg) ? 1'b1 : !is_free_reg[nf_val];
            end
            if (push_en)
            begin
                is_free_reg[push_slot]    <= 1'b1;
                nf_written_reg[push_slot] <= 1'b1;
                free_head_reg             <= push_slot;
                list_empty_reg            <= 1'b0;
            end
            if (cmd.commit_alloc)
            begin
                for (int i = 0; i < CAP_ENTRIES; i++)
                begin
                    if (32'(i) >= 32'(base_reg) && 32'(i) < 32'(base_reg) + 32'(need))
                        taken_reg[i] <= 1'b1;
                end
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            nf_rd_reg  <= nf_mem[free_head_reg];
            dom_rd_reg <= dom_mem[SW'(in_data.domain_slot)];
        end
        if (push_en)
            nf_mem[push_slot] <= free_head_reg;
        if (cmd.commit_alloc)
        begin
            dom_mem[alloc_slot_reg] <= '{base: base_reg, range: RW'(need), used: RW'(1)};
            cap_mem[base_reg] <= '{addr: '0, owner: alloc_slot_reg,
                                   target: 6'(alloc_slot_reg), level: '0};
        end
        if (cmd.commit_add)
        begin
            dom_mem[req_slot] <= '{base: dom_rd_reg.base, range: dom_rd_reg.range,
                                   used: dom_rd_reg.used + 1'b1};
            cap_mem[add_idx] <= '{addr: req_reg.entry_address, owner: req_slot,
                                  target: req_reg.target_slot,
                                  level: req_reg.iso_lvl};
        end
    end

    // request, scan and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= in_data;
            nf_hit_reg   <= nf_written_reg[free_head_reg];
            nf_head_reg  <= free_head_reg;
            slot_bad_reg <= (32'(in_data.domain_slot) >= 32'(DOMAIN_SLOTS)) ||
                            is_free_reg[SW'(in_data.domain_slot)];
        end
        if (cmd.pop)
            alloc_slot_reg <= free_head_reg;
        if (cmd.scan_clear)
        begin
            pos_reg <= '0;
            run_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            pos_reg <= pos_reg + PW'(SCAN_W);
            run_reg <= run_v;
            if (found_v)
                base_reg <= base_v;
        end
        if (cmd.set_result)
        begin
            res_reg.status    <= cmd.res_status;
            res_reg.slot_out  <= cmd.res_use_alloc ? 6'(alloc_slot_reg) : 6'd0;
            res_reg.cap_index <= cmd.res_use_alloc ? 8'(base_reg) :
                                 cmd.res_use_add   ? 8'(add_idx)  : 8'd0;
        end
        if (cmd.load_out)
            out_reg <= res_reg;
    end

    assign out_data = out_reg;

endmodule

@@ rtl/core/cra_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cra_ctrl
// Request sequencer: decode, first-fit scan, commit, result hand-off.
// ----------------------------------------------------------------------------
module cra_ctrl
    import cra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.set_result = 1'b1;
                state_next     = S_RESP;
                cmd.res_status = ST_OK;
                unique case (sts.op)
                    OP_ALLOC:
                    begin
                        if (sts.list_empty)
                            cmd.res_status = ST_NO_DOMAIN;
                        else
                        begin
                            cmd.set_result = 1'b0;
                            cmd.pop        = 1'b1;
                            cmd.scan_clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    OP_FREE:
                    begin
                        if (sts.slot_bad)
                            cmd.res_status = ST_BAD_SLOT;
                        else
                            cmd.push_req_slot = 1'b1;
                    end
                    OP_ADD:
                    begin
                        priority if (sts.slot_bad)
                            cmd.res_status = ST_BAD_SLOT;
                        else if (sts.range_full)
                            cmd.res_status = ST_LIMIT;
                        else if (sts.level_bad)
                            cmd.res_status = ST_BAD_LEVEL;
                        else
                        begin
                            cmd.commit_add  = 1'b1;
                            cmd.res_use_add = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_found)
                    state_next = S_MARK;
                else if (sts.scan_done)
                begin
                    cmd.push_alloc_slot = 1'b1;
                    cmd.set_result      = 1'b1;
                    cmd.res_status      = ST_NO_RANGE;
                    state_next          = S_RESP;
                end
            end
            S_MARK:
            begin
                cmd.commit_alloc  = 1'b1;
                cmd.set_result    = 1'b1;
                cmd.res_status    = ST_OK;
                cmd.res_use_alloc = 1'b1;
                state_next        = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for capability_range_allocator_unit. An in-bench
// allocator model predicts the response of each accepted request. Directed
// tests cover:
//   - the first allocation
//   - range limits and isolation levels
//   - a range too large to fit
//   - slot exhaustion
// Random phases then vary sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import cra_pkg::*;

    localparam int          TABLE_SIZE = 256;
    localparam int          NUM_SLOTS  = 64;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 60;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    req_t       in_data;
    logic       out_valid;
    logic       out_ready;
    rsp_t       out_data;
    logic       cfg_wr_en;
    logic [3:0] cfg_wr_data;

    capability_range_allocator_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // Allocator model state: free list, capability table occupancy and the
    // per-slot reserved range. Entry contents are never read back, so they are
    // not kept.
    // ------------------------------------------------------------------------
    logic          cap_taken   [TABLE_SIZE];
    logic          slot_free   [NUM_SLOTS];
    logic [5:0]    slot_link   [NUM_SLOTS];
    logic [7:0]    slot_base   [NUM_SLOTS];
    logic [8:0]    slot_range  [NUM_SLOTS];
    logic [8:0]    slot_used   [NUM_SLOTS];
    logic [5:0]    list_head;
    logic          list_empty;
    logic [3:0]    level_limit;

    rsp_t          pending_rsp[$];
    int            errors;
    int            rsp_seen;
    int            status_hist[8];
    int            send_idle_pct;
    int            recv_stall_pct;

    task automatic model_reset();
        for (int i = 0; i < TABLE_SIZE; i++)
            cap_taken[i] = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_free[i]  = 1'b1;
            slot_link[i]  = 6'((i + 1) % NUM_SLOTS);
            slot_base[i]  = '0;
            slot_range[i] = '0;
            slot_used[i]  = '0;
        end
        list_head   = '0;
        list_empty  = 1'b0;
        level_limit = 4'd15;
    endtask

    function automatic void push_free_slot(input logic [5:0] s);
        slot_link[s] = list_head;
        list_head    = s;
        slot_free[s] = 1'b1;
        list_empty   = 1'b0;
    endfunction

    // Apply one request to the model and return its response.
    function automatic rsp_t allocator_response(input req_t r);
        rsp_t       rsp;
        logic [5:0] s;
        int         need;
        int         run;
        int         base;
        bit         found;
        rsp = '{status: ST_OK, slot_out: '0, cap_index: '0};
        case (r.op)
            OP_ALLOC:
            begin
                if (list_empty)
                begin
                    rsp.status = ST_NO_DOMAIN;
                    return rsp;
                end
                s            = list_head;
                slot_free[s] = 1'b0;
                list_head    = slot_link[s];
                list_empty   = !slot_free[list_head];
                need  = int'(r.cap_count) + 1;
                run   = 0;
                base  = 0;
                found = 1'b0;
                for (int i = 0; i < TABLE_SIZE && !found; i++)
                begin
                    if (cap_taken[i])
                        run = 0;
                    else
                    begin
                        run++;
                        if (run >= need)
                        begin
                            base  = i + 1 - run;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                begin
                    push_free_slot(s);
                    rsp.status = ST_NO_RANGE;
                    return rsp;
                end
                for (int i = base; i < base + need; i++)
                    cap_taken[i] = 1'b1;
                slot_base[s]  = 8'(base);
                slot_range[s] = 9'(need);
                slot_used[s]  = 9'd1;   // entry 0 is the return capability
                rsp.slot_out  = s;
                rsp.cap_index = 8'(base);
            end
            OP_FREE:
            begin
                if (slot_free[r.domain_slot])
                    rsp.status = ST_BAD_SLOT;
                else
                    push_free_slot(r.domain_slot);
            end
            OP_ADD:
            begin
                s = r.domain_slot;
                if (slot_free[s])
                    rsp.status = ST_BAD_SLOT;
                else if (slot_used[s] >= slot_range[s])
                    rsp.status = ST_LIMIT;       // limit wins over level
                else if (r.iso_lvl > level_limit)
                    rsp.status = ST_BAD_LEVEL;
                else
                begin
                    rsp.cap_index = 8'(slot_base[s] + slot_used[s]);
                    slot_used[s]  = slot_used[s] + 9'd1;
                end
            end
            default: ;   // unused op: no effect, all-zero response
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. in_valid stays high across back-to-back requests; it
    // drops only for a sender gap or when the bench goes idle.
    // ------------------------------------------------------------------------
    task automatic send_request(input req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 200)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        pending_rsp.push_back(allocator_response(r));
    endtask

    function automatic req_t make_req(input logic [1:0] op, input logic [7:0] cnt,
                                      input logic [5:0] slot, input logic [3:0] lvl);
        req_t r;
        r.op              = op;
        r.cap_count       = cnt;
        r.domain_slot     = slot;
        r.entry_address   = $urandom;
        r.target_slot     = 6'($urandom);
        r.iso_lvl         = lvl;
        return r;
    endfunction

    // Drain all responses, let the unit settle, then write the level limit.
    task automatic write_level_limit(input logic [3:0] lvl);
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lvl;
        @(posedge clk);
        level_limit = lvl;
        cfg_wr_en   <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response checker and receiver stall generator
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && out_valid && out_ready)
        begin
            rsp_seen++;
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding: %p", out_data);
                errors++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                status_hist[exp_rsp.status]++;
                if (out_data.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status,
                           out_data.status);
                    errors++;
                end
                if (out_data.slot_out !== exp_rsp.slot_out)
                begin
                    $error("slot_out: expected %0d, got %0d", exp_rsp.slot_out,
                           out_data.slot_out);
                    errors++;
                end
                if (out_data.cap_index !== exp_rsp.cap_index)
                begin
                    $error("cap_index: expected %0d, got %0d", exp_rsp.cap_index,
                           out_data.cap_index);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: cycles with no handshake on either channel
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d responses outstanding",
                     pending_rsp.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_first_alloc();
        send_request(make_req(OP_ALLOC, 8'd0, 6'd0, 4'd0));   // slot 0, base 0
        send_request(make_req(OP_ADD, 8'd0, 6'd0, 4'd0));     // range used up
        send_request(make_req(OP_FREE, 8'd0, 6'd0, 4'd0));
        send_request(make_req(OP_FREE, 8'd0, 6'd0, 4'd0));    // already free
        send_request(make_req(OP_ADD, 8'd0, 6'd63, 4'd0));    // free slot
        send_request(make_req(OP_UNUSED, 8'hFF, 6'd63, 4'd15));
    endtask

    task automatic test_levels();
        req_t r;
        write_level_limit(4'd0);
        send_request(make_req(OP_ALLOC, 8'd3, 6'd0, 4'd0));
        send_request(make_req(OP_ADD, 8'd0, 6'd0, 4'd0));
        send_request(make_req(OP_ADD, 8'd0, 6'd0, 4'd15));    // above limit
        write_level_limit(4'd15);
        r = make_req(OP_ADD, 8'd0, 6'd0, 4'd15);
        r.entry_address = 32'hFFFF_FFFF;
        r.target_slot   = 6'd63;
        send_request(r);
        r = make_req(OP_ADD, 8'd0, 6'd0, 4'd15);
        r.entry_address = '0;
        r.target_slot   = '0;
        send_request(r);
        send_request(make_req(OP_ADD, 8'd0, 6'd0, 4'd15));    // range used up
    endtask

    task automatic test_no_range();
        send_request(make_req(OP_ALLOC, 8'd255, 6'd0, 4'd0));
        send_request(make_req(OP_ALLOC, 8'd1, 6'd0, 4'd0));   // slot came back
    endtask

    task automatic test_slot_exhaustion();
        for (int i = 0; i < NUM_SLOTS; i++)
            send_request(make_req(OP_ALLOC, 8'd0, 6'd0, 4'd0));
        send_request(make_req(OP_FREE, 8'd0, 6'd63, 4'd0));
        send_request(make_req(OP_ALLOC, 8'd0, 6'd0, 4'd0));
        send_request(make_req(OP_ALLOC, 8'd0, 6'd0, 4'd0));   // list empty
    endtask

    // ------------------------------------------------------------------------
    // Random phase: mostly requests on live slots with small ranges.
    // ------------------------------------------------------------------------
    function automatic logic [5:0] pick_slot();
        logic [5:0] live[$];
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!slot_free[i])
                live.push_back(6'(i));
        if (live.size() == 0 || $urandom_range(99) < 15)
            return 6'($urandom);
        return live[$urandom_range(live.size() - 1)];
    endfunction

    task automatic test_random(input int n_items, input int idle_pct,
                               input int stall_pct);
        int         pick;
        logic [1:0] op;
        logic [7:0] cnt;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            op = (pick < 30) ? OP_ALLOC : (pick < 50) ? OP_FREE :
                 (pick < 95) ? OP_ADD : OP_UNUSED;
            pick = $urandom_range(99);
            cnt = (pick < 90) ? 8'($urandom_range(2)) :
                  (pick < 98) ? 8'($urandom_range(15, 3)) : 8'($urandom);
            send_request(make_req(op, cnt, pick_slot(), 4'($urandom)));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        errors         = 0;
        rsp_seen       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (status_hist[i])
            status_hist[i] = 0;
        model_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_alloc();
        test_levels();
        test_no_range();
        test_slot_exhaustion();

        test_random(450, 0, 0);
        write_level_limit(4'($urandom_range(14, 1)));
        test_random(450, 88, 0);
        write_level_limit(4'd0);
        test_random(450, 0, 88);
        write_level_limit(4'd15);
        test_random(450, 10, 10);

        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d responses: ok %0d, no domain %0d, no range %0d",
                 rsp_seen, status_hist[ST_OK], status_hist[ST_NO_DOMAIN],
                 status_hist[ST_NO_RANGE]);
        $display("limit %0d, bad level %0d, bad slot %0d; errors %0d",
                 status_hist[ST_LIMIT], status_hist[ST_BAD_LEVEL],
                 status_hist[ST_BAD_SLOT], errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cra_pkg.sv
rtl/core/cra_datapath.sv
rtl/core/cra_ctrl.sv
rtl/core/capability_range_allocator_unit.sv
tb/testbench.sv
